// ----- rtl/jsu_pkg.sv -----
// Package for the JSON string unescaper: result word type, status codes,
// character constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    localparam int MaxResults = 3;
    localparam int CntW       = $clog2(MaxResults + 1);

    // status codes of a result word
    localparam logic [2:0] StOk      = 3'd0;
    localparam logic [2:0] StNoQuote = 3'd1;
    localparam logic [2:0] StEof     = 3'd2;
    localparam logic [2:0] StEscape  = 3'd3;
    localparam logic [2:0] StHex     = 3'd4;
    localparam logic [2:0] StCodePt  = 3'd5;

    localparam logic [7:0] CharQuote  = 8'h22;
    localparam logic [7:0] CharBslash = 8'h5C;
    localparam logic [7:0] CharSlash  = 8'h2F;
    localparam logic [7:0] CharLowB   = 8'h62;
    localparam logic [7:0] CharLowF   = 8'h66;
    localparam logic [7:0] CharLowN   = 8'h6E;
    localparam logic [7:0] CharLowR   = 8'h72;
    localparam logic [7:0] CharLowT   = 8'h74;
    localparam logic [7:0] CharLowU   = 8'h75;

    localparam logic [7:0] CodeBs  = 8'd8;
    localparam logic [7:0] CodeTab = 8'd9;
    localparam logic [7:0] CodeLf  = 8'd10;
    localparam logic [7:0] CodeFf  = 8'd12;
    localparam logic [7:0] CodeCr  = 8'd13;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       string_end;
        logic [2:0] status;
    } t_result;

    typedef struct packed {
        logic [CntW-1:0]               count;
        t_result [MaxResults-1:0]      res;
    } t_decode;

endpackage

`default_nettype wire

// ----- rtl/jsu_in_if.sv -----
// Input channel of the JSON string unescaper: raw text bytes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_out_if.sv -----
// Output channel of the JSON string unescaper: decoded bytes and status.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_end;
    logic [2:0] status;

    modport source (output valid, output out_byte, output byte_valid, output run_last,
                    output string_end, output status, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                    input string_end, input status, output ready);
endinterface

`default_nettype wire

// ----- rtl/jsu_parser.sv -----
// Parse state and per-byte decode of the JSON string unescaper.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [7:0]      i_byte,
    input  wire logic            i_eoi,
    output jsu_pkg::t_decode     o_dec
);
    import jsu_pkg::*;

    localparam logic [2:0] ModeIdle = 3'd0;
    localparam logic [2:0] ModeBody = 3'd1;
    localparam logic [2:0] ModeEsc  = 3'd2;
    localparam logic [2:0] ModeHex0 = 3'd3;
    localparam logic [2:0] ModeHex1 = 3'd4;
    localparam logic [2:0] ModeHex2 = 3'd5;
    localparam logic [2:0] ModeHex3 = 3'd6;

    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_cp, n_cp;
    t_decode     dec;
    logic [4:0]  hex;
    logic [15:0] cp_full;

    // {ok, value}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    function automatic t_result mk(input logic [7:0] b, input logic v, input logic last,
                                   input logic send, input logic [2:0] st);
        t_result r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.run_last   = last;
        r.string_end = send;
        r.status     = st;
        return r;
    endfunction

    assign hex     = hex_digit(i_byte);
    assign cp_full = {r_cp[11:0], hex[3:0]};

    always_comb begin
        n_mode = r_mode;
        n_cp   = r_cp;
        dec    = '0;
        if (i_eoi) begin
            n_mode = ModeIdle;
            n_cp   = '0;
            dec.count  = CntW'(1);
            dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StEof);
        end else begin
            case (r_mode)
                ModeIdle: begin
                    if (i_byte == CharQuote) begin
                        n_mode = ModeBody;
                    end else begin
                        n_cp       = '0;
                        dec.count  = CntW'(1);
                        dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StNoQuote);
                    end
                end
                ModeBody: begin
                    if (i_byte == CharQuote) begin
                        n_mode     = ModeIdle;
                        n_cp       = '0;
                        dec.count  = CntW'(1);
                        dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b1, StOk);
                    end else if (i_byte == CharBslash) begin
                        n_mode = ModeEsc;
                    end else begin
                        dec.count  = CntW'(1);
                        dec.res[0] = mk(i_byte, 1'b1, 1'b1, 1'b0, StOk);
                    end
                end
                ModeEsc: begin
                    n_mode     = ModeBody;
                    dec.count  = CntW'(1);
                    case (i_byte)
                        CharQuote:  dec.res[0] = mk(CharQuote, 1'b1, 1'b1, 1'b0, StOk);
                        CharBslash: dec.res[0] = mk(CharBslash, 1'b1, 1'b1, 1'b0, StOk);
                        CharSlash:  dec.res[0] = mk(CharSlash, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowB:   dec.res[0] = mk(CodeBs, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowF:   dec.res[0] = mk(CodeFf, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowN:   dec.res[0] = mk(CodeLf, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowR:   dec.res[0] = mk(CodeCr, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowT:   dec.res[0] = mk(CodeTab, 1'b1, 1'b1, 1'b0, StOk);
                        CharLowU: begin
                            n_mode    = ModeHex0;
                            n_cp      = '0;
                            dec.count = '0;
                        end
                        default: begin
                            n_mode     = ModeIdle;
                            n_cp       = '0;
                            dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StEscape);
                        end
                    endcase
                end
                ModeHex0, ModeHex1, ModeHex2, ModeHex3: begin
                    if (!hex[4]) begin
                        n_mode     = ModeIdle;
                        n_cp       = '0;
                        dec.count  = CntW'(1);
                        dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StHex);
                    end else if (r_mode != ModeHex3) begin
                        n_cp   = cp_full;
                        n_mode = r_mode + 3'd1;
                    end else if (cp_full[15:11] == 5'b11011) begin
                        // surrogate half
                        n_mode     = ModeIdle;
                        n_cp       = '0;
                        dec.count  = CntW'(1);
                        dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StCodePt);
                    end else begin
                        n_cp   = cp_full;
                        n_mode = ModeBody;
                        if (cp_full == 16'd0) begin
                            dec.count = '0;
                        end else if (cp_full < 16'h0080) begin
                            dec.count  = CntW'(1);
                            dec.res[0] = mk(cp_full[7:0], 1'b1, 1'b1, 1'b0, StOk);
                        end else if (cp_full < 16'h0800) begin
                            dec.count  = CntW'(2);
                            dec.res[0] = mk({3'b110, cp_full[10:6]}, 1'b1, 1'b0, 1'b0, StOk);
                            dec.res[1] = mk({2'b10, cp_full[5:0]}, 1'b1, 1'b1, 1'b0, StOk);
                        end else begin
                            dec.count  = CntW'(3);
                            dec.res[0] = mk({4'b1110, cp_full[15:12]}, 1'b1, 1'b0, 1'b0,
                                            StOk);
                            dec.res[1] = mk({2'b10, cp_full[11:6]}, 1'b1, 1'b0, 1'b0, StOk);
                            dec.res[2] = mk({2'b10, cp_full[5:0]}, 1'b1, 1'b1, 1'b0, StOk);
                        end
                    end
                end
                default: begin
                    // unused mode code: recover to idle
                    n_mode     = ModeIdle;
                    n_cp       = '0;
                    dec.count  = CntW'(1);
                    dec.res[0] = mk(8'd0, 1'b0, 1'b1, 1'b0, StEof);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= ModeIdle;
            r_cp   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_cp   <= n_cp;
        end
    end

    assign o_dec = dec;

endmodule

`default_nettype wire

// ----- rtl/json_string_unescape_top.sv -----
// Top level of the JSON string unescaper: parser plus result word queue.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and jsu_parser.
//
//  channel  dir  word fields
//  i_in     in   in_byte[7:0], end_of_input
//  o_out    out  out_byte[7:0], byte_valid, run_last, string_end, status[2:0]
//
// One input word is taken per cycle unless the queue holds the input back; its
// results appear in the result register on the next cycle.
// A \u escape giving two or three UTF-8 bytes holds the input while the result
// queue drains at one word per cycle when the output is ready.
// Synchronous active-low reset returns the parser to idle and empties the queue.
// Output stalls back-pressure the input whenever the queue holds a word.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);
    import jsu_pkg::*;

    t_decode                  dec;
    t_result [MaxResults-1:0] r_buf;
    logic [CntW-1:0]          r_cnt;
    logic                     accept;
    logic                     pop;

    assign pop        = (r_cnt != '0) && o_out.ready;
    assign i_in.ready = (r_cnt == '0) || ((r_cnt == CntW'(1)) && o_out.ready);
    assign accept     = i_in.valid && i_in.ready;

    jsu_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eoi    (i_in.end_of_input),
        .o_dec    (dec)
    );

    // load on accept, otherwise shift down on pop
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_buf <= dec.res;
        end else if (pop) begin
            for (int i = 0; i < MaxResults - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= dec.count;
        end else if (pop) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = r_buf[0].out_byte;
    assign o_out.byte_valid = r_buf[0].byte_valid;
    assign o_out.run_last   = r_buf[0].run_last;
    assign o_out.string_end = r_buf[0].string_end;
    assign o_out.status     = r_buf[0].status;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (r_cnt == '0) || (r_cnt == CntW'(1) && pop))
        else $error("input accepted while queue still holds pending words");

    a_last_marks_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CntW'(1)) |-> r_buf[0].run_last)
        else $error("final queued word lacks run_last");

    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0 && r_buf[0].status != StOk) |->
            (!r_buf[0].byte_valid && r_buf[0].run_last && r_cnt == CntW'(1)))
        else $error("error word malformed or not alone");

    a_multi_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && dec.count > CntW'(1)) |=> !i_in.ready || o_out.valid)
        else $error("multi-byte burst lost");

endmodule

`default_nettype wire

// ----- tb/jsu_stream_checker.sv -----
// Checker for the JSON string unescaper: watches both channels, decodes every
// accepted input word and compares each result word with the oldest one due.
// Depends on jsu_pkg, jsu_in_if and jsu_out_if.
`timescale 1ns / 1ps

module jsu_stream_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    jsu_in_if    i_in_mon,
    jsu_out_if   i_out_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_result_count
);
    import jsu_pkg::*;

    localparam int ReportLimit = 10;

    typedef enum logic [2:0] {
        PARSE_IDLE,
        PARSE_BODY,
        PARSE_ESC,
        PARSE_HEX1,
        PARSE_HEX2,
        PARSE_HEX3,
        PARSE_HEX4
    } t_parse_mode;

    t_parse_mode parse_mode  = PARSE_IDLE;
    logic [15:0] code_point  = '0;
    t_result     decoded_words [$];
    int          fail_total   = 0;
    int          result_total = 0;

    function automatic t_result make_word(input logic [7:0] b, input logic byte_ok,
                                          input logic last, input logic str_end,
                                          input logic [2:0] st);
        t_result w;
        w.out_byte   = b;
        w.byte_valid = byte_ok;
        w.run_last   = last;
        w.string_end = str_end;
        w.status     = st;
        return w;
    endfunction

    // append a word to the tail of the expected queue
    task automatic queue_word(input t_result w);
        decoded_words.insert(decoded_words.size(), w);
    endtask

    // drop back to idle with a single error word
    task automatic abort_string(input logic [2:0] st);
        parse_mode = PARSE_IDLE;
        code_point = '0;
        queue_word(make_word(8'h00, 1'b0, 1'b1, 1'b0, st));
    endtask

    task automatic emit_utf8(input logic [15:0] cp);
        if (cp == 16'h0000) begin
            return;
        end
        if (cp < 16'h0080) begin
            queue_word(make_word(cp[7:0], 1'b1, 1'b1, 1'b0, StOk));
        end else if (cp < 16'h0800) begin
            queue_word(make_word({3'b110, cp[10:6]}, 1'b1, 1'b0, 1'b0, StOk));
            queue_word(make_word({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, StOk));
        end else begin
            queue_word(make_word({4'b1110, cp[15:12]}, 1'b1, 1'b0, 1'b0, StOk));
            queue_word(make_word({2'b10, cp[11:6]}, 1'b1, 1'b0, 1'b0, StOk));
            queue_word(make_word({2'b10, cp[5:0]}, 1'b1, 1'b1, 1'b0, StOk));
        end
    endtask

    task automatic decode_word(input logic [7:0] c, input logic eoi);
        logic [7:0]  esc_byte;
        logic [3:0]  nib;
        logic [15:0] cp_next;
        if (eoi) begin
            abort_string(StEof);
            return;
        end
        case (parse_mode)
            PARSE_IDLE: begin
                if (c != CharQuote) begin
                    abort_string(StNoQuote);
                end else begin
                    parse_mode = PARSE_BODY;
                end
            end
            PARSE_BODY: begin
                if (c == CharQuote) begin
                    parse_mode = PARSE_IDLE;
                    code_point = '0;
                    queue_word(make_word(8'h00, 1'b0, 1'b1, 1'b1, StOk));
                end else if (c == CharBslash) begin
                    parse_mode = PARSE_ESC;
                end else begin
                    queue_word(make_word(c, 1'b1, 1'b1, 1'b0, StOk));
                end
            end
            PARSE_ESC: begin
                // a known single-byte escape leaves the mode in the body
                parse_mode = PARSE_BODY;
                esc_byte   = c;
                case (c)
                    CharQuote, CharBslash, CharSlash: ;
                    CharLowB: esc_byte = CodeBs;
                    CharLowF: esc_byte = CodeFf;
                    CharLowN: esc_byte = CodeLf;
                    CharLowR: esc_byte = CodeCr;
                    CharLowT: esc_byte = CodeTab;
                    CharLowU: begin
                        parse_mode = PARSE_HEX1;
                        code_point = '0;
                    end
                    default: abort_string(StEscape);
                endcase
                if (parse_mode == PARSE_BODY) begin
                    queue_word(make_word(esc_byte, 1'b1, 1'b1, 1'b0, StOk));
                end
            end
            default: begin
                // digits sit at 0x3n, letters at 0x4n/0x6n with A/a at n = 1
                if (c inside {["0":"9"]}) begin
                    nib = c[3:0];
                end else if (c inside {["a":"f"], ["A":"F"]}) begin
                    nib = c[3:0] + 4'd9;
                end else begin
                    abort_string(StHex);
                    return;
                end
                cp_next = {code_point[11:0], nib};
                if (parse_mode != PARSE_HEX4) begin
                    code_point = cp_next;
                    parse_mode = t_parse_mode'(parse_mode + 3'd1);
                end else if (cp_next >= 16'hD800 && cp_next <= 16'hDFFF) begin
                    abort_string(StCodePt);
                end else begin
                    code_point = cp_next;
                    parse_mode = PARSE_BODY;
                    emit_utf8(cp_next);
                end
            end
        endcase
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.out_byte   = i_out_mon.out_byte;
        got.byte_valid = i_out_mon.byte_valid;
        got.run_last   = i_out_mon.run_last;
        got.string_end = i_out_mon.string_end;
        got.status     = i_out_mon.status;
        result_total++;
        if (decoded_words.size() == 0) begin
            fail_total++;
            if (fail_total <= ReportLimit) begin
                $display("%0t: unexpected result word: byte %02h valid %0b %s",
                         $realtime, got.out_byte, got.byte_valid,
                         $sformatf("last %0b end %0b status %0d",
                                   got.run_last, got.string_end, got.status));
            end
            return;
        end
        want = decoded_words.pop_front();
        if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
            got.run_last !== want.run_last || got.string_end !== want.string_end ||
            got.status !== want.status) begin
            fail_total++;
            if (fail_total <= ReportLimit) begin
                $display("%0t: result word %0d: expected byte %02h valid %0b %s",
                         $realtime, result_total, want.out_byte, want.byte_valid,
                         $sformatf("last %0b end %0b status %0d",
                                   want.run_last, want.string_end, want.status));
                $display("%0t: result word %0d: actual   byte %02h valid %0b %s",
                         $realtime, result_total, got.out_byte, got.byte_valid,
                         $sformatf("last %0b end %0b status %0d",
                                   got.run_last, got.string_end, got.status));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            parse_mode = PARSE_IDLE;
            code_point = '0;
            decoded_words.delete();
        end else begin
            // results of a word never appear at the edge that takes it
            if (i_out_mon.valid && i_out_mon.ready) begin
                check_result();
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                decode_word(i_in_mon.in_byte, i_in_mon.end_of_input);
            end
        end
        o_pending      <= decoded_words.size();
        o_fail_count   <= fail_total;
        o_result_count <= result_total;
    end

endmodule

// ----- tb/tb_json_string_unescape_top.sv -----
// Testbench top for the JSON string unescaper: clock, reset, byte stimulus
// and output stalls; checking lives in jsu_stream_checker.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and json_string_unescape_top.
`timescale 1ns / 1ps

module tb_json_string_unescape_top;
    import jsu_pkg::*;

    localparam int RandomWords = 360;
    localparam int CycleLimit  = 200000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int words_sent     = 0;
    int strings_sent   = 0;
    int cycle_cnt      = 0;
    int fail_count;
    int pending_words;
    int result_count;

    logic [7:0]  escape_chars [0:7] = '{CharQuote, CharBslash, CharSlash, CharLowB,
                                        CharLowF, CharLowN, CharLowR, CharLowT};
    logic [15:0] code_point_edges [0:7] = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF,
                                            16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

    jsu_in_if  in_ch ();
    jsu_out_if out_ch ();

    json_string_unescape_top u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    jsu_stream_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_mon       (in_ch),
        .i_out_mon      (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending_words),
        .o_result_count (result_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CycleLimit) begin
            $display("timeout after %0d cycles with %0d words outstanding",
                     cycle_cnt, pending_words);
            $display("[json_string_unescape_top] ERROR");
            $finish;
        end
    end

    // hold the word until the block takes it
    task automatic send_word(input logic [7:0] b, input logic eoi);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.in_byte      <= b;
        in_ch.end_of_input <= eoi;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        words_sent++;
    endtask

    // stop sending until every expected result word has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] letter_a;
        letter_a = ($urandom_range(1) == 0) ? "a" : "A";
        if (nib < 4'd10) begin
            return "0" + nib;
        end
        return letter_a + nib - 8'd10;
    endfunction

    task automatic send_code_point(input logic [15:0] cp);
        send_word(CharBslash, 1'b0);
        send_word(CharLowU, 1'b0);
        for (int i = 3; i >= 0; i--) begin
            send_word(hex_digit(cp[i*4 +: 4]), 1'b0);
        end
    endtask

    task automatic send_token();
        int          pick;
        logic [7:0]  b;
        logic [15:0] cp;
        pick = $urandom_range(99);
        if (pick < 40) begin
            do b = 8'($urandom_range(255)); while (b == CharQuote || b == CharBslash);
            send_word(b, 1'b0);
        end else if (pick < 65) begin
            send_word(CharBslash, 1'b0);
            send_word(escape_chars[3'($urandom_range(7))], 1'b0);
        end else begin
            case ($urandom_range(9))
                0:       cp = 16'h0000;
                1, 2:    cp = 16'($urandom_range(16'h007F, 16'h0001));
                3, 4:    cp = 16'($urandom_range(16'h07FF, 16'h0080));
                5, 6, 7: begin
                    cp = 16'($urandom_range(16'hFFFF, 16'h0800));
                    if (cp inside {[16'hD800:16'hDFFF]}) cp ^= 16'h4000;
                end
                default: cp = code_point_edges[3'($urandom_range(7))];
            endcase
            send_code_point(cp);
        end
    endtask

    task automatic send_good_string();
        send_word(CharQuote, 1'b0);
        repeat ($urandom_range(6)) send_token();
        send_word(CharQuote, 1'b0);
        strings_sent++;
    endtask

    // a string that breaks off with an error; the block is idle afterwards
    task automatic send_broken_string();
        logic [7:0] b;
        send_word(CharQuote, 1'b0);
        repeat ($urandom_range(4)) send_token();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(2))
                    0: ;
                    1: send_word(CharBslash, 1'b0);
                    default: begin
                        send_word(CharBslash, 1'b0);
                        send_word(CharLowU, 1'b0);
                        repeat ($urandom_range(3))
                            send_word(hex_digit(4'($urandom_range(15))), 1'b0);
                    end
                endcase
                send_word(8'($urandom_range(255)), 1'b1);
            end
            1: begin
                send_word(CharBslash, 1'b0);
                do b = 8'($urandom_range(255));
                while (b inside {CharQuote, CharBslash, CharSlash, CharLowB, CharLowF,
                                 CharLowN, CharLowR, CharLowT, CharLowU});
                send_word(b, 1'b0);
            end
            2: begin
                send_word(CharBslash, 1'b0);
                send_word(CharLowU, 1'b0);
                repeat ($urandom_range(3))
                    send_word(hex_digit(4'($urandom_range(15))), 1'b0);
                do b = 8'($urandom_range(255));
                while (b inside {["0":"9"], ["a":"f"], ["A":"F"]});
                send_word(b, 1'b0);
            end
            default: send_code_point(16'hD800 + 16'($urandom_range(16'h07FF)));
        endcase
        strings_sent++;
    endtask

    // stray words between strings: no opening quote, or end of input in idle
    task automatic send_noise();
        logic [7:0] b;
        repeat ($urandom_range(3, 1)) begin
            if ($urandom_range(3) == 0) begin
                send_word(8'($urandom_range(255)), 1'b1);
            end else begin
                do b = 8'($urandom_range(255)); while (b == CharQuote);
                send_word(b, 1'b0);
            end
        end
    endtask

    initial begin
        int phase_end;
        int pick;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = 8'h00;
        in_ch.end_of_input = 1'b0;
        out_ch.ready       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: errors from idle, pass-through extremes, escapes, code points
        send_word(8'hFF, 1'b1);
        send_word(8'h00, 1'b0);
        send_word(CharQuote, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(CharBslash, 1'b0);
        send_word(CharLowN, 1'b0);
        send_code_point(16'hFFFF);
        send_code_point(16'h0000);
        send_word(CharQuote, 1'b0);
        send_word(CharQuote, 1'b0);
        send_word(CharBslash, 1'b0);
        send_word("q", 1'b0);
        send_word(CharQuote, 1'b0);
        send_word(8'h00, 1'b1);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            phase_end = words_sent + RandomWords / 4;
            while (words_sent < phase_end) begin
                pick = $urandom_range(99);
                if (pick < 78) begin
                    send_good_string();
                end else if (pick < 93) begin
                    send_broken_string();
                end else begin
                    send_noise();
                end
            end
            drain();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d input words in %0d strings plus stray words, under four",
                 words_sent, strings_sent);
        $display("idle and stall mixes; %0d result words compared.", result_count);
        if (fail_count == 0 && pending_words == 0) begin
            $display("[json_string_unescape_top] OK");
        end else begin
            $display("%0d failures, %0d expected words never arrived", fail_count, pending_words);
            $display("[json_string_unescape_top] ERROR");
        end
        $finish;
    end

endmodule
